// ----- src/crt_pkg.sv -----
// Shared types and constants for the chunk receipt tracker.
// Used by crt_front, crt_back and crt_div; depends on nothing else.

package crt_pkg;

    localparam int ADDR_W   = 32;  // address field width
    localparam int LEN_W    = 25;  // byte_count field width
    localparam int MLEN_W   = 11;  // missing_length field width
    localparam int ROW_BITS = 64;  // bitmap bits per memory row
    localparam int ROW_SH   = 6;   // log2 of ROW_BITS

    localparam int QDEPTH = 2;     // command queue depth
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_MARK  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_MARK,
        CMD_QUERY,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [ADDR_W-1:0]   address;
        logic [LEN_W-1:0]    length;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic init;
    } back_ctl_t;

endpackage

// ----- src/crt_div.sv -----
// Divider by a constant power of two: the quotient is a shift and the remainder a mask,
// both registered and shown with done in the cycle after go. Depends on crt_pkg for the dividend width.

module crt_div
    import crt_pkg::*;
#(
    parameter int DIVISOR = 1024,
    localparam int DRW = $clog2(DIVISOR)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [LEN_W-1:0] dividend,
    output logic             done,
    output logic [LEN_W-1:0] quotient,
    output logic [DRW-1:0]   remainder
);

    logic             done_reg, done_next;
    logic [LEN_W-1:0] quo_reg, quo_next;
    logic [DRW-1:0]   rem_reg, rem_next;

    always_comb
    begin
        done_next = go;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (go)
        begin
            quo_next = dividend >> DRW;
            rem_next = dividend[DRW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/crt_front.sv -----
// Front end: decodes request words, saturates the transfer length and
// queues commands for the back end. Depends on crt_pkg.

module crt_front
    import crt_pkg::*;
#(
    parameter int MAX_CHUNKS  = 16384,
    parameter int CHUNK_BYTES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        req_type,
    input  logic [ADDR_W-1:0] address,
    input  logic [LEN_W-1:0]  byte_count,
    input  back_ctl_t         ctl,
    output logic              busy,
    output logic              cmd_valid,
    output cmd_t              cmd
);

    localparam logic [63:0] CAP = 64'(MAX_CHUNKS) * 64'(CHUNK_BYTES);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    cmd_t              dec;

    always_comb
    begin
        dec.address = address;
        dec.length  = (64'(byte_count) > CAP) ? LEN_W'(CAP) : byte_count;
        unique case (req_type)
            REQ_START: dec.kind = CMD_START;
            REQ_MARK:  dec.kind = CMD_MARK;
            REQ_QUERY: dec.kind = CMD_QUERY;
            default:   dec.kind = CMD_NOP;
        endcase
    end

    assign busy      = (cnt_reg == QCNT_W'(QDEPTH)) || ctl.init;
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !ctl.pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && ctl.pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (ctl.pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end

endmodule

// ----- src/crt_back.sv -----
// Back end: owns the received bitmap memory and the transfer registers,
// and carries out start, mark and query commands. Depends on crt_pkg, crt_div.

module crt_back
    import crt_pkg::*;
#(
    parameter int MAX_CHUNKS  = 16384,
    parameter int CHUNK_BYTES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output back_ctl_t         ctl,
    output logic              done,
    output logic              status,
    output logic              complete,
    output logic [ADDR_W-1:0] missing_address,
    output logic [MLEN_W-1:0] missing_length
);

    localparam int ROWS   = (MAX_CHUNKS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int SCAN_W = $clog2(ROWS * ROW_BITS + ROW_BITS + 1);
    localparam int DRW    = $clog2(CHUNK_BYTES);
    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam int PROD_W = IDX_W + DRW + 1;

    typedef enum logic [8:0] {
        ST_INIT  = 9'b0_0000_0001,
        ST_IDLE  = 9'b0_0000_0010,
        ST_CLEAR = 9'b0_0000_0100,
        ST_MDIV  = 9'b0_0000_1000,
        ST_MRD   = 9'b0_0001_0000,
        ST_MWR   = 9'b0_0010_0000,
        ST_QSCAN = 9'b0_0100_0000,
        ST_QMUL  = 9'b0_1000_0000,
        ST_QOUT  = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_BITS-1:0] map_mem [ROWS];
    logic [ROW_BITS-1:0] rdata_reg;
    logic                mem_we, mem_re;
    logic [ROW_AW-1:0]   mem_waddr, mem_raddr;
    logic [ROW_BITS-1:0] mem_wdata;

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [LEN_W-1:0]  tlen_reg, tlen_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [DRW-1:0]    rem_reg, rem_next;
    logic              rem_nz_reg, rem_nz_next;

    logic [ROW_AW-1:0] clr_row_reg, clr_row_next;
    logic              sweep_fin_reg, sweep_fin_next;
    logic              div_fin_reg, div_fin_next;

    logic [ROW_AW-1:0] row_reg, row_next;
    logic [ROW_SH-1:0] bit_reg, bit_next;

    logic [SCAN_W-1:0] issue_base_reg, issue_base_next;
    logic [ROW_AW-1:0] issue_row_reg, issue_row_next;
    logic              pend_reg, pend_next;
    logic [SCAN_W-1:0] pend_base_reg, pend_base_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PROD_W-1:0] prod_reg;
    logic              last_reg;

    logic              done_reg, done_next;
    logic              status_reg, status_next;
    logic              complete_reg, complete_next;
    logic [ADDR_W-1:0] maddr_reg, maddr_next;
    logic [MLEN_W-1:0] mlen_reg, mlen_next;

    logic              div_go, div_done;
    logic [LEN_W-1:0]  div_din, div_q;
    logic [DRW-1:0]    div_r;

    logic              pop;
    logic [ADDR_W-1:0] off;
    logic              issue;
    logic [SCAN_W-1:0] lim;
    logic [ROW_BITS-1:0] mask, cand;
    logic [ROW_SH-1:0] pos;
    logic              found;

    crt_div #(.DIVISOR(CHUNK_BYTES)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (div_din),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign pop      = (state_reg == ST_IDLE) && cmd_valid;
    assign ctl.pop  = pop;
    assign ctl.init = (state_reg == ST_INIT);
    assign off      = cmd.address - base_reg;
    assign issue    = (issue_base_reg < SCAN_W'(n_reg));

    // Only chunks below the chunk count take part in the search of a row.
    always_comb
    begin
        lim = SCAN_W'(n_reg) - pend_base_reg;
        for (int j = 0; j < ROW_BITS; j++)
            mask[j] = (SCAN_W'(j) < lim);
        cand  = ~rdata_reg & mask;
        found = |cand;
        pos   = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--)
        begin
            if (cand[j])
                pos = ROW_SH'(j);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        tlen_next       = tlen_reg;
        n_next          = n_reg;
        rem_next        = rem_reg;
        rem_nz_next     = rem_nz_reg;
        clr_row_next    = clr_row_reg;
        sweep_fin_next  = sweep_fin_reg;
        div_fin_next    = div_fin_reg;
        row_next        = row_reg;
        bit_next        = bit_reg;
        issue_base_next = issue_base_reg;
        issue_row_next  = issue_row_reg;
        pend_next       = 1'b0;
        pend_base_next  = pend_base_reg;
        idx_next        = idx_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        complete_next   = complete_reg;
        maddr_next      = maddr_reg;
        mlen_next       = mlen_reg;
        div_go          = 1'b0;
        div_din         = cmd.length;
        mem_we          = 1'b0;
        mem_waddr       = clr_row_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = row_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we       = 1'b1;
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_AW'(ROWS - 1))
                begin
                    clr_row_next = '0;
                    state_next   = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    status_next   = 1'b0;
                    complete_next = 1'b0;
                    maddr_next    = '0;
                    mlen_next     = '0;
                    case (cmd.kind)
                        CMD_START:
                        begin
                            base_next      = cmd.address;
                            tlen_next      = cmd.length;
                            div_go         = 1'b1;
                            div_din        = cmd.length;
                            clr_row_next   = '0;
                            sweep_fin_next = 1'b0;
                            div_fin_next   = 1'b0;
                            state_next     = ST_CLEAR;
                        end
                        CMD_MARK:
                        begin
                            if (off >= ADDR_W'(tlen_reg))
                            begin
                                status_next = 1'b1;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                div_go     = 1'b1;
                                div_din    = LEN_W'(off);
                                state_next = ST_MDIV;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (n_reg == '0)
                            begin
                                complete_next = 1'b1;
                                done_next     = 1'b1;
                            end
                            else
                            begin
                                issue_base_next = '0;
                                issue_row_next  = '0;
                                state_next      = ST_QSCAN;
                            end
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end

            ST_CLEAR:
            begin
                if (!sweep_fin_reg)
                begin
                    mem_we       = 1'b1;
                    clr_row_next = clr_row_reg + 1'b1;
                    if (clr_row_reg == ROW_AW'(ROWS - 1))
                        sweep_fin_next = 1'b1;
                end
                if (div_done)
                begin
                    n_next       = CNT_W'(div_q) + CNT_W'(div_r != '0);
                    rem_next     = div_r;
                    rem_nz_next  = (div_r != '0);
                    div_fin_next = 1'b1;
                end
                if (sweep_fin_reg && div_fin_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_MDIV:
            begin
                if (div_done)
                begin
                    row_next   = ROW_AW'(div_q >> ROW_SH);
                    bit_next   = div_q[ROW_SH-1:0];
                    state_next = ST_MRD;
                end
            end

            ST_MRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = row_reg;
                state_next = ST_MWR;
            end

            ST_MWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = row_reg;
                mem_wdata  = rdata_reg | (ROW_BITS'(1) << bit_reg);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_QSCAN:
            begin
                // Reads are issued one row a cycle; each row is checked the
                // cycle after its read while the next read is in flight.
                mem_re         = issue;
                mem_raddr      = issue_row_reg;
                pend_next      = issue;
                pend_base_next = issue_base_reg;
                if (issue)
                begin
                    issue_base_next = issue_base_reg + SCAN_W'(ROW_BITS);
                    issue_row_next  = issue_row_reg + 1'b1;
                end
                if (pend_reg && found)
                begin
                    idx_next   = IDX_W'(pend_base_reg + SCAN_W'(pos));
                    pend_next  = 1'b0;
                    state_next = ST_QMUL;
                end
                else if (pend_reg &&
                         (pend_base_reg + SCAN_W'(ROW_BITS) >= SCAN_W'(n_reg)))
                begin
                    complete_next = 1'b1;
                    done_next     = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            ST_QMUL:
                state_next = ST_QOUT;

            ST_QOUT:
            begin
                maddr_next = base_reg + ADDR_W'(prod_reg);
                // The last chunk carries the tail of the transfer, unless the
                // length is a whole number of chunks.
                mlen_next  = (last_reg && rem_nz_reg) ? MLEN_W'(rem_reg)
                                                      : MLEN_W'(CHUNK_BYTES);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            base_reg       <= '0;
            tlen_reg       <= '0;
            n_reg          <= '0;
            rem_nz_reg     <= 1'b0;
            clr_row_reg    <= '0;
            sweep_fin_reg  <= 1'b0;
            div_fin_reg    <= 1'b0;
            issue_base_reg <= '0;
            issue_row_reg  <= '0;
            pend_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            tlen_reg       <= tlen_next;
            n_reg          <= n_next;
            rem_nz_reg     <= rem_nz_next;
            clr_row_reg    <= clr_row_next;
            sweep_fin_reg  <= sweep_fin_next;
            div_fin_reg    <= div_fin_next;
            issue_base_reg <= issue_base_next;
            issue_row_reg  <= issue_row_next;
            pend_reg       <= pend_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        row_reg       <= row_next;
        bit_reg       <= bit_next;
        pend_base_reg <= pend_base_next;
        idx_reg       <= idx_next;
        prod_reg      <= PROD_W'(idx_reg) * PROD_W'(CHUNK_BYTES);
        last_reg      <= (CNT_W'(idx_reg) == n_reg - 1'b1);
        status_reg    <= status_next;
        complete_reg  <= complete_next;
        maddr_reg     <= maddr_next;
        mlen_reg      <= mlen_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= map_mem[mem_raddr];
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign complete        = complete_reg;
    assign missing_address = maddr_reg;
    assign missing_length  = mlen_reg;

endmodule

// ----- src/chunk_receipt_tracker_unit.sv -----
// Top level of the chunk receipt tracker: front end, command queue and back end.
// Depends on crt_pkg, crt_front, crt_back (and crt_div below it).

// A word is taken when start is high and busy is low; every word gives exactly one
// result, shown for one cycle with done high, and the receiver cannot stall it.
// Up to two words wait in a queue while the back end works. With R =
// ceil(MAX_CHUNKS / 64) bitmap rows (256 by default): a start clears the bitmap
// one row per cycle; a mark finds the chunk index and does a read-modify-write of
// one row, unless it is flagged out of range; a query reads one row per cycle until
// the first missing chunk or the end of the transfer. A query of an empty transfer
// and other words are answered from the idle state. After reset, busy stays high
// while the R rows of the bitmap memory are cleared.

module chunk_receipt_tracker_unit
    import crt_pkg::*;
#(
    parameter int MAX_CHUNKS  = 16384,
    parameter int CHUNK_BYTES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        req_type,
    input  logic [ADDR_W-1:0] address,
    input  logic [LEN_W-1:0]  byte_count,
    output logic              done,
    output logic              status,
    output logic              complete,
    output logic [ADDR_W-1:0] missing_address,
    output logic [MLEN_W-1:0] missing_length
);

    back_ctl_t back_ctl;
    logic      cmd_valid;
    cmd_t      cmd;

    crt_front #(
        .MAX_CHUNKS  (MAX_CHUNKS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .address    (address),
        .byte_count (byte_count),
        .ctl        (back_ctl),
        .busy       (busy),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd)
    );

    crt_back #(
        .MAX_CHUNKS  (MAX_CHUNKS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .ctl             (back_ctl),
        .done            (done),
        .status          (status),
        .complete        (complete),
        .missing_address (missing_address),
        .missing_length  (missing_length)
    );

    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        back_ctl.init |-> busy)
        else $error("bitmap clear in progress while busy is low");

    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        back_ctl.init |-> !done && !back_ctl.pop)
        else $error("result or command pop during bitmap clear");

    a_flag_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> !complete && missing_address == '0 && missing_length == '0)
        else $error("flagged mark carries query fields");

    a_complete_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && complete |-> !status && missing_address == '0 && missing_length == '0)
        else $error("complete query reports a missing chunk");

endmodule

// ----- sim/tb_chunk_receipt_tracker_unit.sv -----
// Testbench for chunk_receipt_tracker_unit: directed and random start, mark, query and other words,
// each checked against an in-bench model of the chunk bitmap. Depends on crt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_chunk_receipt_tracker_unit;
    import crt_pkg::*;

    localparam int unsigned CHUNK      = 1024;
    localparam int unsigned CHUNKS_MAX = 16384;
    localparam int unsigned CAPACITY   = CHUNKS_MAX * CHUNK;
    localparam logic [1:0]  REQ_NOP    = 2'd3;
    localparam int unsigned WORD_GOAL  = 400;

    typedef struct packed {
        logic              status;
        logic              complete;
        logic [ADDR_W-1:0] missing_address;
        logic [MLEN_W-1:0] missing_length;
    } chunk_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  byte_count;
    logic              done;
    logic              status;
    logic              complete;
    logic [ADDR_W-1:0] missing_address;
    logic [MLEN_W-1:0] missing_length;

    // Model of the tracker, updated when a word is accepted.
    logic [ADDR_W-1:0]     xfer_base;
    logic [LEN_W-1:0]      xfer_length;
    logic [CHUNKS_MAX-1:0] received_bits;
    chunk_result_t         expected_results[$];

    // What the stimulus believes the current transfer to be.
    logic [ADDR_W-1:0] plan_base;
    int unsigned       plan_length;
    bit                steady;
    int unsigned       words_sent;
    int unsigned       mismatches;

    chunk_receipt_tracker_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .address         (address),
        .byte_count      (byte_count),
        .done            (done),
        .status          (status),
        .complete        (complete),
        .missing_address (missing_address),
        .missing_length  (missing_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic chunk_result_t apply_request(logic [1:0] req, logic [ADDR_W-1:0] addr,
                                                    logic [LEN_W-1:0] cnt);
        chunk_result_t     r;
        logic [ADDR_W-1:0] offset;
        int unsigned       n;
        int unsigned       i;
        r = '0;
        case (req)
            REQ_START:
            begin
                xfer_base     = addr;
                xfer_length   = (cnt > CAPACITY) ? LEN_W'(CAPACITY) : cnt;
                received_bits = '0;
            end
            REQ_MARK:
            begin
                offset = addr - xfer_base;
                if (offset >= {7'd0, xfer_length})
                    r.status = 1'b1;
                else
                    received_bits[offset / CHUNK] = 1'b1;
            end
            REQ_QUERY:
            begin
                n = (int'(xfer_length) + CHUNK - 1) / CHUNK;
                i = 0;
                while (i < n && received_bits[i])
                    i++;
                if (i == n)
                    r.complete = 1'b1;
                else
                begin
                    r.missing_address = xfer_base + ADDR_W'(i * CHUNK);
                    r.missing_length  = MLEN_W'(CHUNK);
                    // The final chunk may be short unless the length is a whole multiple.
                    if (i == n - 1 && (xfer_length % CHUNK) != 0)
                        r.missing_length = MLEN_W'(xfer_length % CHUNK);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Acceptance and checking share one block so their order within an edge is fixed.
    always @(posedge clk)
    begin
        chunk_result_t want;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no word outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", status, want.status);
                    check_field("complete", complete, want.complete);
                    check_field("missing_address", missing_address, want.missing_address);
                    check_field("missing_length", missing_length, want.missing_length);
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                expected_results.push_back(apply_request(req_type, address, byte_count));
        end
    end

    task automatic send_word(input logic [1:0] req, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] cnt);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= req;
        address    <= addr;
        byte_count <= cnt;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic start_transfer(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len);
        plan_base   = base;
        plan_length = (len > CAPACITY) ? CAPACITY : len;
        send_word(REQ_START, base, len);
    endtask

    // Marks a random byte of chunk k of the current transfer.
    task automatic mark_chunk(input int unsigned k);
        int unsigned lo;
        int unsigned hi;
        lo = k * CHUNK;
        hi = (plan_length - lo > CHUNK) ? lo + CHUNK - 1 : plan_length - 1;
        send_word(REQ_MARK, plan_base + $urandom_range(lo, hi), LEN_W'($urandom));
    endtask

    task automatic mark_outside();
        if ($urandom_range(0, 1) == 0)
            send_word(REQ_MARK, plan_base - $urandom_range(1, 4096), LEN_W'($urandom));
        else
            send_word(REQ_MARK, plan_base + plan_length + $urandom_range(0, 4096),
                      LEN_W'($urandom));
    endtask

    task automatic query();
        send_word(REQ_QUERY, $urandom, LEN_W'($urandom));
    endtask

    task automatic test_after_reset();
        query();
        send_word(REQ_MARK, '0, '0);
        send_word(REQ_NOP, 32'hFFFF_FFFF, '1);
    endtask

    task automatic test_short_last_chunk();
        start_transfer(32'h0000_1000, 25'd2500);
        query();
        send_word(REQ_MARK, 32'h0000_1000, '0);
        send_word(REQ_MARK, 32'h0000_1000 + 1500, '0);
        query();
        send_word(REQ_MARK, 32'h0000_1000 + 2499, '0);
        query();
        send_word(REQ_MARK, 32'h0000_1000, '0);
        send_word(REQ_MARK, 32'h0000_1000 + 2500, '0);
        send_word(REQ_MARK, 32'h0000_0FFF, '0);
    endtask

    // The transfer ends at the top of the address space; a mark at address zero lies past it.
    task automatic test_whole_last_chunk();
        start_transfer(32'hFFFF_F800, 25'd2048);
        send_word(REQ_MARK, 32'hFFFF_F800, '0);
        query();
        send_word(REQ_MARK, 32'h0000_0000, '0);
    endtask

    task automatic test_capacity();
        start_transfer(32'h0000_0000, '1);
        send_word(REQ_MARK, 32'h00FF_FFFF, '0);
        send_word(REQ_MARK, 32'h0100_0000, '0);
        query();
        start_transfer(32'hA5A5_5A5A, '0);
        query();
        send_word(REQ_MARK, 32'hA5A5_5A5A, '0);
    endtask

    task automatic test_random_traffic();
        int unsigned len;
        int unsigned nchunks;
        int unsigned count;
        int unsigned pick;
        int unsigned k;
        while (words_sent < WORD_GOAL)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 2)
            begin
                repeat (4)
                    send_word(2'($urandom_range(0, 3)), $urandom, LEN_W'($urandom));
                continue;
            end
            case ($urandom_range(0, 6))
                0: len = 0;
                1: len = $urandom_range(1, CHUNK);
                2: len = CHUNK * $urandom_range(1, 16);
                3: len = $urandom_range(1, 80000);
                4: len = $urandom_range(1, CAPACITY);
                5: len = CAPACITY;
                default: len = $urandom_range(CAPACITY + 1, (1 << LEN_W) - 1);
            endcase
            start_transfer($urandom, LEN_W'(len));
            nchunks = (plan_length + CHUNK - 1) / CHUNK;
            if (nchunks == 0)
            begin
                mark_outside();
                query();
                continue;
            end
            pick = $urandom_range(0, 2);
            if (pick == 2 && nchunks > 12)
                pick = 1;
            case (pick)
                0:
                begin
                    // Fill a prefix, dropping the odd chunk, so queries scan past row ends.
                    count = $urandom_range(1, 70);
                    if (count > nchunks)
                        count = nchunks;
                    for (k = 0; k < count; k++)
                        if ($urandom_range(0, 15) != 0)
                            mark_chunk(k);
                    query();
                end
                1:
                begin
                    repeat ($urandom_range(1, 10))
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6)
                            mark_chunk($urandom_range(0, (nchunks > 16) ? 15 : nchunks - 1));
                        else if (pick == 6)
                            mark_outside();
                        else if (pick == 7)
                            mark_chunk($urandom_range(0, nchunks - 1));
                        else
                            query();
                    end
                    query();
                end
                default:
                begin
                    for (k = 0; k + 1 < nchunks; k++)
                        mark_chunk(k);
                    query();
                    mark_chunk(nchunks - 1);
                    query();
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req_type   <= REQ_START;
        address    <= '0;
        byte_count <= '0;
        steady      = 1'b0;
        words_sent  = 0;
        mismatches  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_short_last_chunk();
        test_whole_last_chunk();
        test_capacity();
        test_random_traffic();

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
